FILE: sv/svd_pkg.sv
// ----------------------------------------------------------------------------
// svd_pkg
// Shared constants, types and the expected-bit table of the soft Viterbi
// decoder (K=4, rate 1/2, 8 trellis states).
// ----------------------------------------------------------------------------
package svd_pkg;

    localparam int HIST_BITS   = 24;                  // traceback history
    localparam int WINDOW      = HIST_BITS + 8;       // history plus one byte
    localparam int SURV_W      = WINDOW;              // survivor register width
    localparam int NUM_STATES  = 8;
    localparam int HALF_STATES = NUM_STATES / 2;
    localparam int STATE_W     = $clog2(NUM_STATES);
    localparam int COST_W      = 32;
    localparam int SOFT_W      = 8;
    localparam int BC_W        = SOFT_W + 1;          // branch cost width
    localparam int MAX_RESULTS = 5;
    localparam int PEND_W      = $clog2(WINDOW + 1);  // symbols past last byte
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
    localparam int DIST_W      = $clog2(SURV_W);

    localparam logic [COST_W-1:0] COST_INIT  = 32'h7fff_ffff;
    localparam logic [BC_W-1:0]   COST_SUM   = 9'd510;
    localparam logic [SOFT_W-1:0] EXP_ZERO   = 8'hff;
    localparam logic [SOFT_W-1:0] EXP_ONE    = 8'h00;
    localparam logic [7:0]        LIMIT_INIT = 8'hff;

    typedef logic [COST_W-1:0]                   cost_t;
    typedef logic [SURV_W-1:0]                   surv_t;
    typedef logic [NUM_STATES-1:0][COST_W-1:0]   cost_vec_t;
    typedef logic [NUM_STATES-1:0][SURV_W-1:0]   surv_vec_t;

    // Emission job handed from the ACS side to the byte output side
    typedef struct packed {
        logic [PEND_W-1:0] diff;      // symbols decoded beyond emitted bits
        logic              is_final;  // packet flush requested
    } job_t;

    // Expected soft values {first, second} for state pair s
    function automatic logic [2*SOFT_W-1:0] expect_pair(input logic [1:0] s);
        logic [2*SOFT_W-1:0] pat;
        case (s)
            2'd0:    pat = {EXP_ZERO, EXP_ZERO};
            2'd1:    pat = {EXP_ZERO, EXP_ONE};
            2'd2:    pat = {EXP_ONE,  EXP_ONE};
            2'd3:    pat = {EXP_ONE,  EXP_ZERO};
            default: pat = {EXP_ZERO, EXP_ZERO};
        endcase
        return pat;
    endfunction

endpackage

FILE: sv/soft_viterbi_decoder_top.sv
// ----------------------------------------------------------------------------
// soft_viterbi_decoder_top
// Soft-decision Viterbi decoder, K=4 rate 1/2, 8 states, byte output.
// ----------------------------------------------------------------------------
// Path: a byte caused by an input transfer passes the input register, the
//   trellis snapshot of the ACS result, three min-search levels and the output
//   register; flush bytes follow one per cycle while the output is not stalled.
// Throughput: one symbol pair per cycle; a pair that releases a byte waits
//   while the byte unit still works on the last one.
// Reset: path costs to state 0, survivors and counters cleared, byte limit 255.
// ----------------------------------------------------------------------------
module soft_viterbi_decoder_top (
    input  logic        clk,
    input  logic        rst_n,
    // symbol pair channel
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  soft_first,
    input  logic [7:0]  soft_second,
    input  logic        final_pair,
    // decoded byte channel
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  data_byte,
    output logic        run_last,
    output logic        packet_done,
    // byte limit register write
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  byte_limit
);

    // Input register: decouples the upstream handshake from the ACS stall
    logic                           in_valid_reg;
    logic [7:0]                     soft_first_reg;
    logic [7:0]                     soft_second_reg;
    logic                           final_reg;

    // Decoder control state
    logic [svd_pkg::PEND_W-1:0]     pend_reg;     // symbols past the last byte
    logic                           halted_reg;   // packet ended, drop input
    logic                           started_reg;  // a symbol has been decoded

    logic                           in_xfer;
    logic                           win_hit;
    logic                           needs_job;
    logic                           proc;
    logic                           step;
    logic                           job_load;
    logic                           cfg_load;
    logic                           emit_idle;
    logic                           halt_set;
    svd_pkg::job_t                  job;
    svd_pkg::cost_vec_t             cost_next;
    svd_pkg::surv_vec_t             surv_next;

    // A byte is due when the window is full, or on a flush with bits pending.
    // Such a pair needs the byte unit free, since it snapshots the trellis.
    assign win_hit   = pend_reg >= svd_pkg::PEND_W'(svd_pkg::WINDOW);
    assign needs_job = win_hit || (final_reg && (pend_reg != '0));

    // Pairs after the halt are taken and dropped without touching the trellis
    assign proc     = in_valid_reg && (halted_reg || !needs_job || emit_idle);
    assign step     = proc && !halted_reg;
    assign job_load = step && needs_job;
    assign in_ready = !in_valid_reg || proc;
    assign in_xfer  = in_valid && in_ready;

    assign job.diff     = pend_reg;
    assign job.is_final = final_reg;

    // The limit write reloads the down-counter only before the first symbol
    assign cfg_ready = 1'b1;
    assign cfg_load  = cfg_valid && !started_reg && !halted_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            pend_reg     <= '0;
            halted_reg   <= 1'b0;
            started_reg  <= 1'b0;
        end
        else
        begin
            if (in_xfer)
                in_valid_reg <= 1'b1;
            else if (proc)
                in_valid_reg <= 1'b0;
            if (step)
            begin
                // one more symbol; a window byte retires eight of them
                pend_reg    <= pend_reg + svd_pkg::PEND_W'(1)
                             - (win_hit ? svd_pkg::PEND_W'(8) : '0);
                started_reg <= 1'b1;
            end
            if ((step && final_reg) || halt_set)
                halted_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            soft_first_reg  <= soft_first;
            soft_second_reg <= soft_second;
            final_reg       <= final_pair;
        end
    end

    svd_acs u_acs (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .soft_first  (soft_first_reg),
        .soft_second (soft_second_reg),
        .cost_next   (cost_next),
        .surv_next   (surv_next)
    );

    svd_emit u_emit (
        .clk         (clk),
        .rst_n       (rst_n),
        .job_load    (job_load),
        .job         (job),
        .cost_in     (cost_next),
        .surv_in     (surv_next),
        .cfg_load    (cfg_load),
        .cfg_value   (byte_limit),
        .out_ready   (out_ready),
        .idle        (emit_idle),
        .halt_set    (halt_set),
        .out_valid   (out_valid),
        .data_byte   (data_byte),
        .run_last    (run_last),
        .packet_done (packet_done)
    );

endmodule

FILE: sv/svd_acs.sv
// ----------------------------------------------------------------------------
// svd_acs
// Eight add-compare-select units with the path cost and survivor registers.
// ----------------------------------------------------------------------------
module svd_acs (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  step,
    input  logic [svd_pkg::SOFT_W-1:0]            soft_first,
    input  logic [svd_pkg::SOFT_W-1:0]            soft_second,
    output svd_pkg::cost_vec_t                    cost_next,
    output svd_pkg::surv_vec_t                    surv_next
);

    svd_pkg::cost_vec_t cost_reg;
    svd_pkg::surv_vec_t surv_reg;

    always_comb
    begin
        logic [2*svd_pkg::SOFT_W-1:0] pat;
        logic [svd_pkg::BC_W-1:0]     bc;
        logic [svd_pkg::BC_W-1:0]     bc_inv;
        svd_pkg::cost_t               m0;
        svd_pkg::cost_t               m1;
        logic                         pick;
        cost_next = cost_reg;
        surv_next = surv_reg;
        for (int s = 0; s < svd_pkg::HALF_STATES; s++)
        begin
            pat    = svd_pkg::expect_pair(2'(s));
            bc     = {1'b0, soft_first  ^ pat[2*svd_pkg::SOFT_W-1:svd_pkg::SOFT_W]}
                   + {1'b0, soft_second ^ pat[svd_pkg::SOFT_W-1:0]};
            bc_inv = svd_pkg::COST_SUM - bc;

            // even target: direct cost from s, mirrored from s + half
            m0   = cost_reg[s] + svd_pkg::COST_W'(bc);
            m1   = cost_reg[s + svd_pkg::HALF_STATES] + svd_pkg::COST_W'(bc_inv);
            pick = m0 > m1;   // ties keep the lower predecessor
            cost_next[2*s] = pick ? m1 : m0;
            surv_next[2*s] = pick
                ? {surv_reg[s + svd_pkg::HALF_STATES][svd_pkg::SURV_W-2:0], 1'(s)}
                : {surv_reg[s][svd_pkg::SURV_W-2:0], 1'(s)};

            // odd target: costs swap roles
            m0   = cost_reg[s] + svd_pkg::COST_W'(bc_inv);
            m1   = cost_reg[s + svd_pkg::HALF_STATES] + svd_pkg::COST_W'(bc);
            pick = m0 > m1;
            cost_next[2*s+1] = pick ? m1 : m0;
            surv_next[2*s+1] = pick
                ? {surv_reg[s + svd_pkg::HALF_STATES][svd_pkg::SURV_W-2:0], 1'(s)}
                : {surv_reg[s][svd_pkg::SURV_W-2:0], 1'(s)};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < svd_pkg::NUM_STATES; s++)
            begin
                cost_reg[s] <= svd_pkg::COST_INIT;
                surv_reg[s] <= '0;
            end
            cost_reg[0] <= '0;
        end
        else if (step)
        begin
            cost_reg <= cost_next;
            surv_reg <= surv_next;
        end
    end

endmodule

FILE: sv/svd_emit.sv
// ----------------------------------------------------------------------------
// svd_emit
// Byte output side: snapshots the trellis, finds the lowest-cost state in a
// three-level registered tree, then reads bytes from its survivor into the
// output register. Holds the remaining byte count.
// ----------------------------------------------------------------------------
module svd_emit (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  job_load,
    input  svd_pkg::job_t         job,
    input  svd_pkg::cost_vec_t    cost_in,
    input  svd_pkg::surv_vec_t    surv_in,
    input  logic                  cfg_load,
    input  logic [7:0]            cfg_value,
    input  logic                  out_ready,
    output logic                  idle,
    output logic                  halt_set,
    output logic                  out_valid,
    output logic [7:0]            data_byte,
    output logic                  run_last,
    output logic                  packet_done
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_LVL1 = 3'd1;
    localparam logic [2:0] ST_LVL2 = 3'd2;
    localparam logic [2:0] ST_LVL3 = 3'd3;
    localparam logic [2:0] ST_EMIT = 3'd4;

    logic [2:0]                     state_reg;
    logic [2:0]                     state_next;
    svd_pkg::cost_vec_t             cost_snap_reg;
    svd_pkg::surv_vec_t             surv_snap_reg;
    logic [svd_pkg::PEND_W-1:0]     diff_reg;
    logic                           is_final_reg;
    logic [svd_pkg::CNT_W-1:0]      cnt_reg;
    svd_pkg::cost_t                 l1_cost_reg [4];
    logic [svd_pkg::STATE_W-1:0]    l1_idx_reg  [4];
    svd_pkg::cost_t                 l2_cost_reg [2];
    logic [svd_pkg::STATE_W-1:0]    l2_idx_reg  [2];
    logic [svd_pkg::STATE_W-1:0]    best_reg;
    svd_pkg::surv_t                 surv_sel_reg;
    logic [7:0]                     bytes_left_reg;
    logic                           out_valid_reg;
    logic [7:0]                     data_reg;
    logic                           run_last_reg;
    logic                           done_reg;

    svd_pkg::cost_t                 l1_cost_next [4];
    logic [svd_pkg::STATE_W-1:0]    l1_idx_next  [4];
    svd_pkg::cost_t                 l2_cost_next [2];
    logic [svd_pkg::STATE_W-1:0]    l2_idx_next  [2];
    logic [svd_pkg::STATE_W-1:0]    best_next;

    logic                           out_free;
    logic                           fire;
    logic                           tail;
    logic [svd_pkg::DIST_W-1:0]     shift_amt;
    svd_pkg::surv_t                 shifted;
    logic [7:0]                     byte_val;
    logic [7:0]                     left_dec;
    logic                           limit_hit;
    logic [svd_pkg::CNT_W-1:0]      cnt_inc;
    logic                           more;
    logic                           cap;
    logic                           go_on;

    // Minimum search; strict compare keeps the lower index on ties
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            if (cost_snap_reg[2*i+1] < cost_snap_reg[2*i])
            begin
                l1_cost_next[i] = cost_snap_reg[2*i+1];
                l1_idx_next[i]  = svd_pkg::STATE_W'(2*i+1);
            end
            else
            begin
                l1_cost_next[i] = cost_snap_reg[2*i];
                l1_idx_next[i]  = svd_pkg::STATE_W'(2*i);
            end
        end
        for (int i = 0; i < 2; i++)
        begin
            if (l1_cost_reg[2*i+1] < l1_cost_reg[2*i])
            begin
                l2_cost_next[i] = l1_cost_reg[2*i+1];
                l2_idx_next[i]  = l1_idx_reg[2*i+1];
            end
            else
            begin
                l2_cost_next[i] = l1_cost_reg[2*i];
                l2_idx_next[i]  = l1_idx_reg[2*i];
            end
        end
        best_next = (l2_cost_reg[1] < l2_cost_reg[0]) ? l2_idx_reg[1] : l2_idx_reg[0];
    end

    // Byte extraction
    always_comb
    begin
        out_free  = !out_valid_reg || out_ready;
        fire      = (state_reg == ST_EMIT) && out_free;
        tail      = diff_reg < svd_pkg::PEND_W'(8);
        shift_amt = svd_pkg::DIST_W'(diff_reg - svd_pkg::PEND_W'(8));
        shifted   = surv_sel_reg >> shift_amt;
        // short tail: best state's low bit shifted in, low byte taken
        byte_val  = tail ? {surv_sel_reg[6:0], best_reg[0]} : shifted[7:0];
        left_dec  = bytes_left_reg - 8'd1;
        limit_hit = left_dec == 8'd0;
        cnt_inc   = cnt_reg + svd_pkg::CNT_W'(1);
        // a loaded diff never exceeds the window, so only a flush runs on
        more      = is_final_reg && (diff_reg > svd_pkg::PEND_W'(8)) && !limit_hit;
        cap       = more && (cnt_inc >= svd_pkg::CNT_W'(svd_pkg::MAX_RESULTS));
        go_on     = more && !cap;
        halt_set  = fire && (limit_hit || cap);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (job_load) state_next = ST_LVL1;
            ST_LVL1: state_next = ST_LVL2;
            ST_LVL2: state_next = ST_LVL3;
            ST_LVL3: state_next = ST_EMIT;
            ST_EMIT: if (fire && !go_on) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            bytes_left_reg <= svd_pkg::LIMIT_INIT;
            out_valid_reg  <= 1'b0;
            diff_reg       <= '0;
            is_final_reg   <= 1'b0;
            cnt_reg        <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_load)
                bytes_left_reg <= cfg_value;
            else if (fire)
                bytes_left_reg <= left_dec;
            if (fire)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            if (state_reg == ST_IDLE && job_load)
            begin
                diff_reg     <= job.diff;
                is_final_reg <= job.is_final;
                cnt_reg      <= '0;
            end
            else if (fire)
            begin
                diff_reg <= diff_reg - svd_pkg::PEND_W'(8);
                cnt_reg  <= cnt_inc;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && job_load)
        begin
            cost_snap_reg <= cost_in;
            surv_snap_reg <= surv_in;
        end
        if (state_reg == ST_LVL1)
        begin
            l1_cost_reg <= l1_cost_next;
            l1_idx_reg  <= l1_idx_next;
        end
        if (state_reg == ST_LVL2)
        begin
            l2_cost_reg <= l2_cost_next;
            l2_idx_reg  <= l2_idx_next;
        end
        if (state_reg == ST_LVL3)
        begin
            best_reg     <= best_next;
            surv_sel_reg <= surv_snap_reg[best_next];
        end
        if (fire)
        begin
            data_reg     <= byte_val;
            run_last_reg <= !go_on;
            done_reg     <= limit_hit || (!go_on && is_final_reg);
        end
    end

    assign idle        = state_reg == ST_IDLE;
    assign out_valid   = out_valid_reg;
    assign data_byte   = data_reg;
    assign run_last    = run_last_reg;
    assign packet_done = done_reg;

endmodule
